@@ hw/rtl/ssl_pkg.sv @@
// Shared types, constants and saturation helpers for the soft spring link solver.
`timescale 1ns / 1ps
`default_nettype none

package ssl_pkg;

    // Default number of fraction bits of the fixed point format.
    localparam int FRAC_BITS_DEF = 16;

    // Number of two-bit steps of the square root unit.
    localparam int SQ_ITER = 32;

    // Request codes.
    localparam logic [1:0] REQ_PRESTEP = 2'd0;
    localparam logic [1:0] REQ_SUBSTEP = 2'd1;
    localparam logic [1:0] REQ_RECOMP  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_TIME_STEP = 3'd0;
    localparam logic [2:0] REG_STIFFNESS = 3'd1;
    localparam logic [2:0] REG_DAMPING   = 3'd2;
    localparam logic [2:0] REG_INV_MASS_A = 3'd3;
    localparam logic [2:0] REG_INV_MASS_B = 3'd4;
    localparam logic [2:0] REG_REST_LEN  = 3'd5;
    localparam logic [2:0] REG_FIXED     = 3'd6;

    // Configuration reset values.
    localparam logic [30:0] RST_TIME_STEP = 31'd1092;
    localparam logic [30:0] RST_ONE       = 31'd65536;

    // Signed 32-bit limits.
    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // Status of an iterative arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } ssl_unit_sts_t;

    // Sequencer states.
    typedef enum logic [5:0] {
        ST_IDLE,
        ST_RC_IM, ST_RC_M, ST_RC_MW, ST_RC_W0, ST_RC_W1, ST_RC_WW,
        ST_RC_D0, ST_RC_D1, ST_RC_D2, ST_RC_D3, ST_RC_D4, ST_RC_GW,
        ST_RC_E0, ST_RC_EW,
        ST_PS_DIFF, ST_PS_SQ0, ST_PS_SQ1, ST_PS_SQ2, ST_PS_SQW,
        ST_PS_DX, ST_PS_DXW, ST_PS_DY, ST_PS_DYW,
        ST_PS_B0, ST_PS_B1, ST_PS_B2, ST_PS_B3, ST_PS_B4, ST_PS_B5,
        ST_SS_DIFF, ST_SS_0, ST_SS_1, ST_SS_2, ST_SS_3, ST_SS_4,
        ST_AP0, ST_AP1, ST_AP2, ST_AP3, ST_AP4, ST_AP5, ST_AP6,
        ST_FIN
    } ssl_state_t;

    // Saturate a 64-bit signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) r = S32_MAX;
        else if (v < -64'sd2147483648) r = S32_MIN;
        else r = v[31:0];
        return r;
    endfunction

    // Sign extend a 32-bit value to 64 bits.
    function automatic logic signed [63:0] sext64(input logic signed [31:0] a);
        return {{32{a[31]}}, a};
    endfunction

    // Zero extend a 32-bit unsigned value to a signed 64-bit value.
    function automatic logic signed [63:0] zext64(input logic [31:0] a);
        return $signed({32'd0, a});
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ssl_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module ssl_div #(
    parameter int DW = 48
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [DW-1:0]          dividend,
    input  wire logic [31:0]            divisor,
    output logic [DW-1:0]               quotient,
    output ssl_pkg::ssl_unit_sts_t      sts
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg;
    logic [31:0]   rem_reg;
    logic [31:0]   dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [32:0]   rem_sh;
    logic          ge;
    logic [32:0]   rem_sub;

    // One trial subtraction per cycle.
    assign rem_sh  = {rem_reg, quo_reg[DW-1]};
    assign ge      = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    // Control of the iteration count.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[31:0] : rem_sh[31:0];
            quo_reg <= {quo_reg[DW-2:0], ge};
        end
    end

    assign quotient = quo_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

`default_nettype wire

@@ hw/rtl/ssl_sqrt.sv @@
// Integer square root of a 64-bit value, two radicand bits per cycle.
`timescale 1ns / 1ps
`default_nettype none

module ssl_sqrt (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [63:0]            radicand,
    output logic [31:0]                 root,
    output ssl_pkg::ssl_unit_sts_t      sts
);

    localparam int CW = $clog2(ssl_pkg::SQ_ITER + 1);

    logic [63:0]   rad_reg;
    logic [33:0]   rem_reg;
    logic [31:0]   root_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [35:0]   rem_sh;
    logic [35:0]   trial;
    logic          ge;
    logic [35:0]   rem_sub;

    // Trial subtraction of the next root bit.
    assign rem_sh  = {rem_reg, rad_reg[63:62]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign ge      = rem_sh >= trial;
    assign rem_sub = rem_sh - trial;

    // Control of the iteration count.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(ssl_pkg::SQ_ITER);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder, root and radicand shift registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[61:0], 2'b00};
            rem_reg  <= ge ? rem_sub[33:0] : rem_sh[33:0];
            root_reg <= {root_reg[30:0], ge};
        end
    end

    assign root     = root_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

`default_nettype wire

@@ hw/rtl/soft_spring_link_solver_unit.sv @@
// Top level of the soft spring link solver: registers, sequencer and shared multiplier.
`timescale 1ns / 1ps
`default_nettype none

// One item is in work at a time; in_stall stays high until its result is in the output
// register. A substep runs on the shared 32x32 multiplier. A prestep runs one 32-step
// square root and, unless the distance is zero, two divisions of 32+FRAC_BITS steps each.
// A recompute of a link that is not fully fixed runs one square root and up to three
// reciprocals. A new item is taken while the previous result still waits on out_stall.
module soft_spring_link_solver_unit #(
    parameter int FRAC_BITS = ssl_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,

    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         req_type,
    input  wire logic signed [31:0] pos_a_x,
    input  wire logic signed [31:0] pos_a_y,
    input  wire logic signed [31:0] pos_b_x,
    input  wire logic signed [31:0] pos_b_y,
    input  wire logic signed [31:0] vel_a_x,
    input  wire logic signed [31:0] vel_a_y,
    input  wire logic signed [31:0] vel_b_x,
    input  wire logic signed [31:0] vel_b_y,
    input  wire logic [30:0]        length_scale,

    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      new_vel_a_x,
    output logic signed [31:0]      new_vel_a_y,
    output logic signed [31:0]      new_vel_b_x,
    output logic signed [31:0]      new_vel_b_y,
    output logic signed [31:0]      step_impulse,
    output logic signed [31:0]      total_impulse,
    output logic                    link_is_active
);

    localparam int DW = 32 + FRAC_BITS;
    localparam logic [DW-1:0] RECIP_NUM =
        {{(DW - 2 * FRAC_BITS - 1){1'b0}}, 1'b1, {(2 * FRAC_BITS){1'b0}}};
    localparam logic [DW-1:0] Q_MAX  = {{(DW - 32){1'b0}}, 32'h7fff_ffff};
    localparam logic [DW-1:0] Q_HALF = {{(DW - 32){1'b0}}, 32'h8000_0000};

    // Configuration registers.
    logic [30:0] time_step_reg;
    logic [30:0] stiffness_reg;
    logic [30:0] damping_reg;
    logic [30:0] ima_reg;
    logic [30:0] imb_reg;
    logic [30:0] rest_len_reg;
    logic [1:0]  fixed_reg;

    // Link state.
    logic signed [31:0] dir_x_reg;
    logic signed [31:0] dir_y_reg;
    logic signed [31:0] bias_reg;
    logic signed [31:0] gamma_reg;
    logic signed [31:0] em_reg;
    logic signed [31:0] acc_reg;
    logic               active_reg;

    // Working registers of the current item.
    logic [1:0]         req_reg;
    logic signed [31:0] pax_reg, pay_reg, pbx_reg, pby_reg;
    logic signed [31:0] v0_reg, v1_reg, v2_reg, v3_reg;
    logic [30:0]        ls_reg;
    logic signed [31:0] im_reg;
    logic signed [31:0] m_reg;
    logic signed [31:0] tmp_reg;
    logic signed [31:0] dx_reg;
    logic signed [31:0] dy_reg;
    logic [63:0]        sum_reg;
    logic [31:0]        d_reg;
    logic               neg_reg;
    logic signed [31:0] imp_reg;
    logic signed [31:0] step_reg;
    logic signed [63:0] prod_reg;

    // Output register.
    logic               out_valid_reg;
    logic signed [31:0] o_v0_reg, o_v1_reg, o_v2_reg, o_v3_reg;
    logic signed [31:0] o_step_reg, o_total_reg;
    logic               o_active_reg;

    ssl_pkg::ssl_state_t state_reg, state_next;

    // Shared unit controls.
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod_full;
    logic               div_start;
    logic [DW-1:0]      div_dividend;
    logic [31:0]        div_divisor;
    logic [DW-1:0]      div_quo;
    ssl_pkg::ssl_unit_sts_t div_sts;
    logic               sqrt_start;
    logic [63:0]        sqrt_rad;
    logic [31:0]        sqrt_root;
    ssl_pkg::ssl_unit_sts_t sqrt_sts;

    // Derived values.
    logic               in_xfer;
    logic               cfg_wr;
    logic               fin_go;
    logic signed [63:0] prod_sh;
    logic signed [31:0] fm;
    logic signed [31:0] recip_val;
    logic signed [31:0] dir_val;
    logic signed [31:0] im2_val;
    logic signed [31:0] imp_val;
    logic signed [31:0] tmp_fm;
    logic [31:0]        abs_dx, abs_dy;

    assign in_xfer = in_valid && !in_stall;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign fin_go  = (state_reg == ssl_pkg::ST_FIN) && (!out_valid_reg || !out_stall);

    // Fixed point product: floor shift and saturate.
    assign prod_full = mul_a * mul_b;
    assign prod_sh   = prod_reg >>> FRAC_BITS;
    assign fm        = ssl_pkg::sat32(prod_sh);

    // Reciprocal clamp and signed quotient of the direction division.
    assign recip_val = (div_quo > Q_MAX) ? ssl_pkg::S32_MAX : $signed(div_quo[31:0]);
    always_comb
    begin
        if (neg_reg)
            dir_val = (div_quo >= Q_HALF) ? ssl_pkg::S32_MIN : -$signed(div_quo[31:0]);
        else
            dir_val = recip_val;
    end

    assign im2_val = ssl_pkg::sat32(ssl_pkg::sext64(im_reg) + ssl_pkg::sext64(gamma_reg));
    assign imp_val = ssl_pkg::sat32(-ssl_pkg::sext64(fm));
    assign tmp_fm  = ssl_pkg::sat32(ssl_pkg::sext64(tmp_reg) + ssl_pkg::sext64(fm));
    assign abs_dx  = dx_reg[31] ? 32'(-dx_reg) : 32'(dx_reg);
    assign abs_dy  = dy_reg[31] ? 32'(-dy_reg) : 32'(dy_reg);

    // Configuration port.
    assign pready = 1'b1;
    always_comb
    begin
        unique case (paddr[4:2])
            ssl_pkg::REG_TIME_STEP:  prdata = {1'b0, time_step_reg};
            ssl_pkg::REG_STIFFNESS:  prdata = {1'b0, stiffness_reg};
            ssl_pkg::REG_DAMPING:    prdata = {1'b0, damping_reg};
            ssl_pkg::REG_INV_MASS_A: prdata = {1'b0, ima_reg};
            ssl_pkg::REG_INV_MASS_B: prdata = {1'b0, imb_reg};
            ssl_pkg::REG_REST_LEN:   prdata = {1'b0, rest_len_reg};
            ssl_pkg::REG_FIXED:      prdata = {30'd0, fixed_reg};
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            time_step_reg <= ssl_pkg::RST_TIME_STEP;
            stiffness_reg <= ssl_pkg::RST_ONE;
            damping_reg   <= ssl_pkg::RST_ONE;
            ima_reg       <= ssl_pkg::RST_ONE;
            imb_reg       <= ssl_pkg::RST_ONE;
            rest_len_reg  <= ssl_pkg::RST_ONE;
            fixed_reg     <= 2'b00;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                ssl_pkg::REG_TIME_STEP:  time_step_reg <= pwdata[30:0];
                ssl_pkg::REG_STIFFNESS:  stiffness_reg <= pwdata[30:0];
                ssl_pkg::REG_DAMPING:    damping_reg   <= pwdata[30:0];
                ssl_pkg::REG_INV_MASS_A: ima_reg       <= pwdata[30:0];
                ssl_pkg::REG_INV_MASS_B: imb_reg       <= pwdata[30:0];
                ssl_pkg::REG_REST_LEN:   rest_len_reg  <= pwdata[30:0];
                ssl_pkg::REG_FIXED:      fixed_reg     <= pwdata[1:0];
                default:                 ;
            endcase
        end
    end

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ssl_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    priority if (req_type == ssl_pkg::REQ_RECOMP)
                        state_next = ssl_pkg::ST_RC_IM;
                    else if (req_type == ssl_pkg::REQ_PRESTEP && active_reg)
                        state_next = ssl_pkg::ST_PS_DIFF;
                    else if (req_type == ssl_pkg::REQ_SUBSTEP && active_reg)
                        state_next = ssl_pkg::ST_SS_DIFF;
                    else
                        state_next = ssl_pkg::ST_FIN;
                end
            end
            ssl_pkg::ST_RC_IM:
                state_next = (fixed_reg == 2'b11) ? ssl_pkg::ST_FIN : ssl_pkg::ST_RC_M;
            ssl_pkg::ST_RC_M:
                state_next = (im_reg == 32'sd0) ? ssl_pkg::ST_RC_W0 : ssl_pkg::ST_RC_MW;
            ssl_pkg::ST_RC_MW:
                if (div_sts.done) state_next = ssl_pkg::ST_RC_W0;
            ssl_pkg::ST_RC_W0: state_next = ssl_pkg::ST_RC_W1;
            ssl_pkg::ST_RC_W1: state_next = ssl_pkg::ST_RC_WW;
            ssl_pkg::ST_RC_WW:
                if (sqrt_sts.done) state_next = ssl_pkg::ST_RC_D0;
            ssl_pkg::ST_RC_D0: state_next = ssl_pkg::ST_RC_D1;
            ssl_pkg::ST_RC_D1: state_next = ssl_pkg::ST_RC_D2;
            ssl_pkg::ST_RC_D2: state_next = ssl_pkg::ST_RC_D3;
            ssl_pkg::ST_RC_D3: state_next = ssl_pkg::ST_RC_D4;
            ssl_pkg::ST_RC_D4:
                state_next = (fm <= 32'sd0) ? ssl_pkg::ST_RC_E0 : ssl_pkg::ST_RC_GW;
            ssl_pkg::ST_RC_GW:
                if (div_sts.done) state_next = ssl_pkg::ST_RC_E0;
            ssl_pkg::ST_RC_E0:
                state_next = (im2_val <= 32'sd0) ? ssl_pkg::ST_FIN : ssl_pkg::ST_RC_EW;
            ssl_pkg::ST_RC_EW:
                if (div_sts.done) state_next = ssl_pkg::ST_FIN;
            ssl_pkg::ST_PS_DIFF: state_next = ssl_pkg::ST_PS_SQ0;
            ssl_pkg::ST_PS_SQ0:  state_next = ssl_pkg::ST_PS_SQ1;
            ssl_pkg::ST_PS_SQ1:  state_next = ssl_pkg::ST_PS_SQ2;
            ssl_pkg::ST_PS_SQ2:  state_next = ssl_pkg::ST_PS_SQW;
            ssl_pkg::ST_PS_SQW:
                if (sqrt_sts.done)
                    state_next = (sqrt_root == 32'd0) ? ssl_pkg::ST_FIN : ssl_pkg::ST_PS_DX;
            ssl_pkg::ST_PS_DX: state_next = ssl_pkg::ST_PS_DXW;
            ssl_pkg::ST_PS_DXW:
                if (div_sts.done) state_next = ssl_pkg::ST_PS_DY;
            ssl_pkg::ST_PS_DY: state_next = ssl_pkg::ST_PS_DYW;
            ssl_pkg::ST_PS_DYW:
                if (div_sts.done) state_next = ssl_pkg::ST_PS_B0;
            ssl_pkg::ST_PS_B0: state_next = ssl_pkg::ST_PS_B1;
            ssl_pkg::ST_PS_B1: state_next = ssl_pkg::ST_PS_B2;
            ssl_pkg::ST_PS_B2: state_next = ssl_pkg::ST_PS_B3;
            ssl_pkg::ST_PS_B3: state_next = ssl_pkg::ST_PS_B4;
            ssl_pkg::ST_PS_B4: state_next = ssl_pkg::ST_PS_B5;
            ssl_pkg::ST_PS_B5: state_next = ssl_pkg::ST_AP0;
            ssl_pkg::ST_SS_DIFF: state_next = ssl_pkg::ST_SS_0;
            ssl_pkg::ST_SS_0: state_next = ssl_pkg::ST_SS_1;
            ssl_pkg::ST_SS_1: state_next = ssl_pkg::ST_SS_2;
            ssl_pkg::ST_SS_2: state_next = ssl_pkg::ST_SS_3;
            ssl_pkg::ST_SS_3: state_next = ssl_pkg::ST_SS_4;
            ssl_pkg::ST_SS_4: state_next = ssl_pkg::ST_AP0;
            ssl_pkg::ST_AP0:
                state_next = (imp_reg == 32'sd0) ? ssl_pkg::ST_FIN : ssl_pkg::ST_AP1;
            ssl_pkg::ST_AP1: state_next = ssl_pkg::ST_AP2;
            ssl_pkg::ST_AP2: state_next = ssl_pkg::ST_AP3;
            ssl_pkg::ST_AP3: state_next = ssl_pkg::ST_AP4;
            ssl_pkg::ST_AP4: state_next = ssl_pkg::ST_AP5;
            ssl_pkg::ST_AP5: state_next = ssl_pkg::ST_AP6;
            ssl_pkg::ST_AP6: state_next = ssl_pkg::ST_FIN;
            ssl_pkg::ST_FIN:
                if (fin_go) state_next = ssl_pkg::ST_IDLE;
            default: state_next = ssl_pkg::ST_IDLE;
        endcase
    end

    // Operand selection for the shared multiplier, divider and square root.
    always_comb
    begin
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = RECIP_NUM;
        div_divisor  = 32'(im_reg);
        sqrt_start   = 1'b0;
        sqrt_rad     = 64'(prod_reg);
        unique case (state_reg)
            ssl_pkg::ST_RC_M:
                div_start = (im_reg != 32'sd0);
            ssl_pkg::ST_RC_W0:
            begin
                mul_a = $signed({1'b0, stiffness_reg});
                mul_b = im_reg;
            end
            ssl_pkg::ST_RC_W1:
                sqrt_start = 1'b1;
            ssl_pkg::ST_RC_D0:
            begin
                mul_a = m_reg;
                mul_b = $signed({1'b0, damping_reg});
            end
            ssl_pkg::ST_RC_D1:
            begin
                mul_a = fm;
                mul_b = tmp_reg;
            end
            ssl_pkg::ST_RC_D2:
            begin
                mul_a = $signed({1'b0, time_step_reg});
                mul_b = $signed({1'b0, stiffness_reg});
            end
            ssl_pkg::ST_RC_D3:
            begin
                mul_a = $signed({1'b0, time_step_reg});
                mul_b = tmp_fm;
            end
            ssl_pkg::ST_RC_D4:
            begin
                div_start   = (fm > 32'sd0);
                div_divisor = 32'(fm);
            end
            ssl_pkg::ST_RC_E0:
            begin
                div_start   = (im2_val > 32'sd0);
                div_divisor = 32'(im2_val);
            end
            ssl_pkg::ST_PS_SQ0:
            begin
                mul_a = dx_reg;
                mul_b = dx_reg;
            end
            ssl_pkg::ST_PS_SQ1:
            begin
                mul_a = dy_reg;
                mul_b = dy_reg;
            end
            ssl_pkg::ST_PS_SQ2:
            begin
                sqrt_start = 1'b1;
                sqrt_rad   = sum_reg + 64'(prod_reg);
            end
            ssl_pkg::ST_PS_DX:
            begin
                div_start    = 1'b1;
                div_dividend = {abs_dx, {FRAC_BITS{1'b0}}};
                div_divisor  = d_reg;
            end
            ssl_pkg::ST_PS_DY:
            begin
                div_start    = 1'b1;
                div_dividend = {abs_dy, {FRAC_BITS{1'b0}}};
                div_divisor  = d_reg;
            end
            ssl_pkg::ST_PS_B0:
            begin
                mul_a = $signed({1'b0, ls_reg});
                mul_b = $signed({1'b0, rest_len_reg});
            end
            ssl_pkg::ST_PS_B2:
            begin
                mul_a = tmp_reg;
                mul_b = $signed({1'b0, time_step_reg});
            end
            ssl_pkg::ST_PS_B3:
            begin
                mul_a = fm;
                mul_b = $signed({1'b0, stiffness_reg});
            end
            ssl_pkg::ST_PS_B4:
            begin
                mul_a = fm;
                mul_b = gamma_reg;
            end
            ssl_pkg::ST_SS_0:
            begin
                mul_a = dir_x_reg;
                mul_b = dx_reg;
            end
            ssl_pkg::ST_SS_1:
            begin
                mul_a = dir_y_reg;
                mul_b = dy_reg;
            end
            ssl_pkg::ST_SS_2:
            begin
                mul_a = gamma_reg;
                mul_b = acc_reg;
            end
            ssl_pkg::ST_SS_3:
            begin
                mul_a = em_reg;
                mul_b = tmp_fm;
            end
            ssl_pkg::ST_AP0:
            begin
                mul_a = imp_reg;
                mul_b = dir_x_reg;
            end
            ssl_pkg::ST_AP1:
            begin
                mul_a = imp_reg;
                mul_b = dir_y_reg;
            end
            ssl_pkg::ST_AP2:
            begin
                mul_a = dx_reg;
                mul_b = $signed({1'b0, ima_reg});
            end
            ssl_pkg::ST_AP3:
            begin
                mul_a = dy_reg;
                mul_b = $signed({1'b0, ima_reg});
            end
            ssl_pkg::ST_AP4:
            begin
                mul_a = dx_reg;
                mul_b = $signed({1'b0, imb_reg});
            end
            ssl_pkg::ST_AP5:
            begin
                mul_a = dy_reg;
                mul_b = $signed({1'b0, imb_reg});
            end
            default: ;
        endcase
    end

    // Sequencer state and output register handshake.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg     <= ssl_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fin_go)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Link state kept between items.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            dir_x_reg  <= '0;
            dir_y_reg  <= '0;
            bias_reg   <= '0;
            gamma_reg  <= '0;
            em_reg     <= '0;
            acc_reg    <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ssl_pkg::ST_RC_IM: active_reg <= (fixed_reg != 2'b11);
                ssl_pkg::ST_RC_D4:
                    if (fm <= 32'sd0) gamma_reg <= ssl_pkg::S32_MAX;
                ssl_pkg::ST_RC_GW:
                    if (div_sts.done) gamma_reg <= recip_val;
                ssl_pkg::ST_RC_E0:
                begin
                    acc_reg <= '0;
                    if (im2_val <= 32'sd0) em_reg <= '0;
                end
                ssl_pkg::ST_RC_EW:
                    if (div_sts.done) em_reg <= recip_val;
                ssl_pkg::ST_PS_DXW:
                    if (div_sts.done) dir_x_reg <= dir_val;
                ssl_pkg::ST_PS_DYW:
                    if (div_sts.done) dir_y_reg <= dir_val;
                ssl_pkg::ST_PS_B5: bias_reg <= fm;
                ssl_pkg::ST_SS_4:
                    acc_reg <= ssl_pkg::sat32(ssl_pkg::sext64(acc_reg)
                                              + ssl_pkg::sext64(imp_val));
                default: ;
            endcase
        end
    end

    // Working registers of the item in progress.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full;
        unique case (state_reg)
            ssl_pkg::ST_IDLE:
                if (in_xfer)
                begin
                    req_reg  <= req_type;
                    pax_reg  <= pos_a_x;
                    pay_reg  <= pos_a_y;
                    pbx_reg  <= pos_b_x;
                    pby_reg  <= pos_b_y;
                    v0_reg   <= vel_a_x;
                    v1_reg   <= vel_a_y;
                    v2_reg   <= vel_b_x;
                    v3_reg   <= vel_b_y;
                    ls_reg   <= length_scale;
                    step_reg <= '0;
                end
            ssl_pkg::ST_RC_IM:
                im_reg <= ssl_pkg::sat32(ssl_pkg::zext64({1'b0, ima_reg})
                                         + ssl_pkg::zext64({1'b0, imb_reg}));
            ssl_pkg::ST_RC_M:
                if (im_reg == 32'sd0) m_reg <= '0;
            ssl_pkg::ST_RC_MW:
                if (div_sts.done) m_reg <= recip_val;
            ssl_pkg::ST_RC_WW:
                if (sqrt_sts.done) tmp_reg <= ssl_pkg::sat32(ssl_pkg::zext64(sqrt_root));
            ssl_pkg::ST_RC_D2:
                tmp_reg <= ssl_pkg::sat32(ssl_pkg::sext64(fm) + ssl_pkg::sext64(fm));
            ssl_pkg::ST_PS_DIFF:
            begin
                dx_reg <= ssl_pkg::sat32(ssl_pkg::sext64(pbx_reg) - ssl_pkg::sext64(pax_reg));
                dy_reg <= ssl_pkg::sat32(ssl_pkg::sext64(pby_reg) - ssl_pkg::sext64(pay_reg));
            end
            ssl_pkg::ST_PS_SQ1: sum_reg <= 64'(prod_reg);
            ssl_pkg::ST_PS_SQW:
                if (sqrt_sts.done) d_reg <= sqrt_root;
            ssl_pkg::ST_PS_DX: neg_reg <= dx_reg[31];
            ssl_pkg::ST_PS_DY: neg_reg <= dy_reg[31];
            ssl_pkg::ST_PS_B1:
                tmp_reg <= ssl_pkg::sat32(ssl_pkg::zext64(d_reg) - ssl_pkg::sext64(fm));
            ssl_pkg::ST_PS_B5:
            begin
                imp_reg  <= acc_reg;
                step_reg <= acc_reg;
            end
            ssl_pkg::ST_SS_DIFF:
            begin
                dx_reg <= ssl_pkg::sat32(ssl_pkg::sext64(v2_reg) - ssl_pkg::sext64(v0_reg));
                dy_reg <= ssl_pkg::sat32(ssl_pkg::sext64(v3_reg) - ssl_pkg::sext64(v1_reg));
            end
            ssl_pkg::ST_SS_1: tmp_reg <= fm;
            ssl_pkg::ST_SS_2:
                tmp_reg <= ssl_pkg::sat32(ssl_pkg::sext64(tmp_fm) + ssl_pkg::sext64(bias_reg));
            ssl_pkg::ST_SS_4:
            begin
                imp_reg  <= imp_val;
                step_reg <= imp_val;
            end
            ssl_pkg::ST_AP1: dx_reg <= fm;
            ssl_pkg::ST_AP2: dy_reg <= fm;
            ssl_pkg::ST_AP3:
                if (!fixed_reg[0])
                    v0_reg <= ssl_pkg::sat32(ssl_pkg::sext64(v0_reg) - ssl_pkg::sext64(fm));
            ssl_pkg::ST_AP4:
                if (!fixed_reg[0])
                    v1_reg <= ssl_pkg::sat32(ssl_pkg::sext64(v1_reg) - ssl_pkg::sext64(fm));
            ssl_pkg::ST_AP5:
                if (!fixed_reg[1])
                    v2_reg <= ssl_pkg::sat32(ssl_pkg::sext64(v2_reg) + ssl_pkg::sext64(fm));
            ssl_pkg::ST_AP6:
                if (!fixed_reg[1])
                    v3_reg <= ssl_pkg::sat32(ssl_pkg::sext64(v3_reg) + ssl_pkg::sext64(fm));
            default: ;
        endcase
    end

    // Result register, loaded when the finished item can be handed over.
    always_ff @(posedge clk)
    begin
        if (fin_go)
        begin
            o_v0_reg     <= v0_reg;
            o_v1_reg     <= v1_reg;
            o_v2_reg     <= v2_reg;
            o_v3_reg     <= v3_reg;
            o_step_reg   <= step_reg;
            o_total_reg  <= acc_reg;
            o_active_reg <= active_reg;
        end
    end

    // Shared iterative units.
    ssl_div #(
        .DW(DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .sts      (div_sts)
    );

    ssl_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_rad),
        .root     (sqrt_root),
        .sts      (sqrt_sts)
    );

    assign in_stall       = (state_reg != ssl_pkg::ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign new_vel_a_x    = o_v0_reg;
    assign new_vel_a_y    = o_v1_reg;
    assign new_vel_b_x    = o_v2_reg;
    assign new_vel_b_y    = o_v3_reg;
    assign step_impulse   = o_step_reg;
    assign total_impulse  = o_total_reg;
    assign link_is_active = o_active_reg;

    // The divider is never restarted while it is still iterating.
    a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_sts.busy)
        else $error("divider started while busy");

    // The square root unit is never restarted while it is still iterating.
    a_sqrt_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_start |-> !sqrt_sts.busy)
        else $error("square root started while busy");

    // A division wait state always has a division in flight.
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ssl_pkg::ST_RC_MW || state_reg == ssl_pkg::ST_RC_GW ||
         state_reg == ssl_pkg::ST_RC_EW || state_reg == ssl_pkg::ST_PS_DXW ||
         state_reg == ssl_pkg::ST_PS_DYW) |-> (div_sts.busy || div_sts.done))
        else $error("waiting on an idle divider");

    // Finishing an item presents its result and frees the input side.
    a_fin_result: assert property (@(posedge clk) disable iff (!rst_n)
        fin_go |=> (out_valid_reg && state_reg == ssl_pkg::ST_IDLE))
        else $error("finished item not presented");

endmodule

`default_nettype wire

@@ sim/ssl_checker.sv @@
// Channel monitor, fixed point predictor and result comparator for the spring link solver.
`timescale 1ns / 1ps

module ssl_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    input  wire logic               pready,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic [1:0]         req_type,
    input  wire logic signed [31:0] pos_a_x,
    input  wire logic signed [31:0] pos_a_y,
    input  wire logic signed [31:0] pos_b_x,
    input  wire logic signed [31:0] pos_b_y,
    input  wire logic signed [31:0] vel_a_x,
    input  wire logic signed [31:0] vel_a_y,
    input  wire logic signed [31:0] vel_b_x,
    input  wire logic signed [31:0] vel_b_y,
    input  wire logic [30:0]        length_scale,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic signed [31:0] new_vel_a_x,
    input  wire logic signed [31:0] new_vel_a_y,
    input  wire logic signed [31:0] new_vel_b_x,
    input  wire logic signed [31:0] new_vel_b_y,
    input  wire logic signed [31:0] step_impulse,
    input  wire logic signed [31:0] total_impulse,
    input  wire logic               link_is_active,
    output int                      fail_count,
    output int                      pending
);
    import ssl_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;

    typedef struct {
        longint va_x;
        longint va_y;
        longint vb_x;
        longint vb_y;
        longint step;
        longint total;
        bit     active;
    } link_result_t;

    link_result_t expected_q[$];

    // Shadow registers and solver state.
    longint cfg_dt, cfg_k, cfg_damp, cfg_ima, cfg_imb, cfg_rest;
    logic [1:0] cfg_fixed;
    longint dir_x, dir_y, bias, gamma, eff_mass, acc_imp;
    bit     active;
    longint vel[4];

    function automatic longint clamp32(longint v);
        if (v > QMAX) return QMAX;
        if (v < QMIN) return QMIN;
        return v;
    endfunction

    // Product floored after the shift.
    function automatic longint qmul(longint a, longint b);
        longint p;
        p = a * b;
        return clamp32(p >>> FRAC);
    endfunction

    // Quotient truncated toward zero.
    function automatic longint qdiv(longint a, longint unsigned b);
        longint unsigned ua, q;
        ua = (a < 0) ? longint'(-a) : longint'(a);
        q = (ua << FRAC) / b;
        if (q > 64'd2147483648) q = 64'd2147483648;
        return clamp32(a < 0 ? -longint'(q) : longint'(q));
    endfunction

    function automatic longint qrecip(longint x);
        longint unsigned q;
        q = (64'd1 << (2 * FRAC)) / longint'(x);
        if (q > 64'd2147483647) return QMAX;
        return longint'(q);
    endfunction

    function automatic longint unsigned root64(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Apply impulse p along the link direction to the working velocities.
    function automatic void push_impulse(longint p);
        longint px, py;
        if (p == 0) return;
        px = qmul(p, dir_x);
        py = qmul(p, dir_y);
        if (!cfg_fixed[0]) begin
            vel[0] = clamp32(vel[0] - qmul(px, cfg_ima));
            vel[1] = clamp32(vel[1] - qmul(py, cfg_ima));
        end
        if (!cfg_fixed[1]) begin
            vel[2] = clamp32(vel[2] + qmul(px, cfg_imb));
            vel[3] = clamp32(vel[3] + qmul(py, cfg_imb));
        end
    endfunction

    function automatic void derive_constants();
        longint im, m, w, dmp, den, g, im2;
        active = (cfg_fixed != 2'b11);
        if (!active) return;
        im = clamp32(cfg_ima + cfg_imb);
        m = (im == 0) ? 0 : qrecip(im);
        w = clamp32(longint'(root64(longint'(cfg_k * im))));
        dmp = clamp32(2 * qmul(qmul(m, cfg_damp), w));
        den = qmul(cfg_dt, clamp32(dmp + qmul(cfg_dt, cfg_k)));
        g = (den <= 0) ? QMAX : qrecip(den);
        gamma = g;
        im2 = clamp32(im + g);
        eff_mass = (im2 <= 0) ? 0 : qrecip(im2);
        acc_imp = 0;
    endfunction

    // Work out the result of one accepted transfer and update the state.
    function automatic link_result_t solve_item();
        link_result_t r;
        longint step, dx, dy, diff, b, rvx, rvy, vr, t, imp;
        longint unsigned d;
        step = 0;
        vel[0] = vel_a_x;
        vel[1] = vel_a_y;
        vel[2] = vel_b_x;
        vel[3] = vel_b_y;
        if (req_type == REQ_RECOMP) begin
            derive_constants();
        end else if (req_type == REQ_PRESTEP && active) begin
            dx = clamp32(longint'(pos_b_x) - longint'(pos_a_x));
            dy = clamp32(longint'(pos_b_y) - longint'(pos_a_y));
            d = root64(longint'(dx * dx) + longint'(dy * dy));
            if (d > 0) begin
                dir_x = qdiv(dx, d);
                dir_y = qdiv(dy, d);
                diff = clamp32(longint'(d) - qmul(longint'(length_scale), cfg_rest));
                b = qmul(diff, cfg_dt);
                b = qmul(b, cfg_k);
                bias = qmul(b, gamma);
                push_impulse(acc_imp);
                step = acc_imp;
            end
        end else if (req_type == REQ_SUBSTEP && active) begin
            rvx = clamp32(vel[2] - vel[0]);
            rvy = clamp32(vel[3] - vel[1]);
            vr = clamp32(qmul(dir_x, rvx) + qmul(dir_y, rvy));
            t = clamp32(vr + bias);
            t = clamp32(t + qmul(gamma, acc_imp));
            imp = clamp32(-qmul(eff_mass, t));
            acc_imp = clamp32(acc_imp + imp);
            push_impulse(imp);
            step = imp;
        end
        r.va_x = vel[0];
        r.va_y = vel[1];
        r.vb_x = vel[2];
        r.vb_y = vel[3];
        r.step = step;
        r.total = acc_imp;
        r.active = active;
        return r;
    endfunction

    function automatic bit field_bad(string name, longint want, longint got);
        if (want == got) return 0;
        if (fail_count < 10)
            $display("%0t: %s expected %0d, got %0d", $realtime, name, want, got);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        link_result_t want;
        bit bad;
        if (!rst_n) begin
            cfg_dt = 1092;
            cfg_k = 65536;
            cfg_damp = 65536;
            cfg_ima = 65536;
            cfg_imb = 65536;
            cfg_rest = 65536;
            cfg_fixed = 2'b00;
            dir_x = 0;
            dir_y = 0;
            bias = 0;
            gamma = 0;
            eff_mass = 0;
            acc_imp = 0;
            active = 0;
            expected_q.delete();
            fail_count = 0;
            pending = 0;
        end else begin
            // Register writes from the configuration port.
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_TIME_STEP:  cfg_dt = longint'(pwdata[30:0]);
                    REG_STIFFNESS:  cfg_k = longint'(pwdata[30:0]);
                    REG_DAMPING:    cfg_damp = longint'(pwdata[30:0]);
                    REG_INV_MASS_A: cfg_ima = longint'(pwdata[30:0]);
                    REG_INV_MASS_B: cfg_imb = longint'(pwdata[30:0]);
                    REG_REST_LEN:   cfg_rest = longint'(pwdata[30:0]);
                    REG_FIXED:      cfg_fixed = pwdata[1:0];
                    default: ;
                endcase
            end
            // Input transfer: predict.
            if (in_valid && !in_stall)
                expected_q.push_back(solve_item());
            // Output transfer: compare with the oldest prediction.
            if (out_valid && !out_stall) begin
                if (expected_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: result with nothing expected", $realtime);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    bad = 0;
                    bad |= field_bad("new_vel_a_x", want.va_x, new_vel_a_x);
                    bad |= field_bad("new_vel_a_y", want.va_y, new_vel_a_y);
                    bad |= field_bad("new_vel_b_x", want.vb_x, new_vel_b_x);
                    bad |= field_bad("new_vel_b_y", want.vb_y, new_vel_b_y);
                    bad |= field_bad("step_impulse", want.step, step_impulse);
                    bad |= field_bad("total_impulse", want.total, total_impulse);
                    bad |= field_bad("link_is_active", want.active, link_is_active);
                    if (bad) fail_count++;
                end
            end
            pending = expected_q.size();
        end
    end

endmodule

@@ sim/tb.sv @@
// Testbench top: clock, reset, stimulus and configuration phases, and the final verdict.
`timescale 1ns / 1ps

module tb;
    import ssl_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] req_type = REQ_PRESTEP;
    logic signed [31:0] pos_a_x = 0, pos_a_y = 0, pos_b_x = 0, pos_b_y = 0;
    logic signed [31:0] vel_a_x = 0, vel_a_y = 0, vel_b_x = 0, vel_b_y = 0;
    logic [30:0] length_scale = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y;
    logic signed [31:0] step_impulse, total_impulse;
    logic link_is_active;
    int fail_count, pending;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    soft_spring_link_solver_unit u_top (.*);

    ssl_checker u_checker (.*);

    initial begin
        forever #6 clk = ~clk;
    end

    initial begin
        #60_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Receiver stall, with an occasional long hold-off.
    always @(posedge clk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= 800;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Offer one transfer and wait until it is accepted.
    task automatic send_item(logic [1:0] req, int pax, int pay, int pbx, int pby,
                             int vax, int vay, int vbx, int vby, logic [30:0] ls);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        pos_a_x <= pax;
        pos_a_y <= pay;
        pos_b_x <= pbx;
        pos_b_y <= pby;
        vel_a_x <= vax;
        vel_a_y <= vay;
        vel_b_x <= vbx;
        vel_b_y <= vby;
        length_scale <= ls;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Random value, mostly moderate, sometimes full range.
    function automatic int rand_q();
        int r;
        r = $urandom;
        return r >>> $urandom_range(20);
    endfunction

    function automatic logic [30:0] rand_scale();
        if ($urandom_range(9) == 0) return 31'($urandom);
        return 31'($urandom_range(131072, 32768));
    endfunction

    task automatic random_item(logic [1:0] req);
        send_item(req, rand_q(), rand_q(), rand_q(), rand_q(),
                  rand_q(), rand_q(), rand_q(), rand_q(), rand_scale());
    endtask

    // Wait until every expected result is back, then let the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_all(int dt, int k, int dmp, int ima, int imb, int rest, int fx);
        reg_write(REG_TIME_STEP, dt);
        reg_write(REG_STIFFNESS, k);
        reg_write(REG_DAMPING, dmp);
        reg_write(REG_INV_MASS_A, ima);
        reg_write(REG_INV_MASS_B, imb);
        reg_write(REG_REST_LEN, rest);
        reg_write(REG_FIXED, fx);
    endtask

    // Random part: mostly a prestep followed by substeps, with some noise.
    task automatic random_phase(int count);
        int n, pick, subs;
        n = 0;
        while (n < count) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                random_item(REQ_RECOMP);
                n++;
            end else if (pick < 13) begin
                random_item(2'($urandom));
                n++;
            end else begin
                random_item(REQ_PRESTEP);
                subs = $urandom_range(6, 1);
                repeat (subs) random_item(REQ_SUBSTEP);
                n += subs + 1;
            end
        end
    endtask

    initial begin
        int ph;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset settings.
        random_item(REQ_PRESTEP);
        random_item(REQ_SUBSTEP);
        random_item(REQ_RECOMP);
        send_item(REQ_PRESTEP, 0, 0, 0, 0, 0, 0, 0, 0, 31'd65536);
        send_item(REQ_PRESTEP, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
                  32'sh7fff_ffff, 0, 0, 0, 0, 31'h7fff_ffff);
        send_item(REQ_SUBSTEP, 32'sh7fff_ffff, 0, 0, 0, 32'sh8000_0000,
                  32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 31'd0);
        send_item(REQ_PRESTEP, 0, 0, 32'sh0003_0000, 32'sh0004_0000,
                  -1, -1, -1, -1, 31'd65536);
        random_item(REQ_SUBSTEP);
        random_item(REQ_SUBSTEP);
        send_item(2'd3, -1, -1, -1, -1, -1, -1, -1, -1, 31'h7fff_ffff);
        send_item(REQ_PRESTEP, 32'sh7fff_ffff, 0, 32'sh8000_0000, 0,
                  0, 0, 0, 0, 31'd0);
        random_item(REQ_SUBSTEP);
        random_item(REQ_RECOMP);
        random_item(REQ_SUBSTEP);

        for (ph = 0; ph < 7; ph++) begin
            drain();
            case (ph)
                1: write_all(1092, 65536 * 20, 32768, 65536, 131072, 131072, 0);
                2: write_all(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1);
                3: write_all(1, 0, 0, 0, 0, 1, 2);
                4: write_all(655, 65536 * 4, 65536, 65536, 65536, 65536, 3);
                5: write_all($urandom_range(4000, 100), $urandom_range(1 << 22),
                             $urandom_range(1 << 18), $urandom_range(1 << 18),
                             $urandom_range(1 << 18), $urandom_range(1 << 20), 0);
                6: write_all($urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom);
                default: ;
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 57; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 57; end
                default: begin send_idle_pct = 30; stall_pct = 30; end
            endcase
            random_item(REQ_RECOMP);
            if (ph == 1 || ph == 5) hold_req++;
            random_phase(190);
        end

        drain();
        repeat (300) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/ssl_pkg.sv
hw/rtl/ssl_div.sv
hw/rtl/ssl_sqrt.sv
hw/rtl/soft_spring_link_solver_unit.sv
sim/ssl_checker.sv
sim/tb.sv
